[src/button_gesture_classifier_core_defines.svh]
// Assertion macros shared by the button gesture classifier checkers.
`ifndef BUTTON_GESTURE_CLASSIFIER_CORE_DEFINES_SVH
`define BUTTON_GESTURE_CLASSIFIER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and ignored while reset is active.
`define BGC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and ignored while reset is active.
`define BGC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/bgc_pkg.sv]
// Types and constants of the button gesture classifier.
package bgc_pkg;

	localparam int TICK_WIDTH_DEF = 16;
	localparam int CFG_DATA_W     = 16;
	localparam int CFG_INDEX_W    = 3;
	localparam int CODE_W         = 4;
	localparam int TRIG_W         = 2;

	localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RESET = 16'd100;

	typedef enum logic [TRIG_W-1:0] {
		TRIG_NONE   = 2'd0,
		TRIG_CLICK  = 2'd1,
		TRIG_DOUBLE = 2'd2,
		TRIG_LONG   = 2'd3
	} trig_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ENABLED     = 3'd0,
		REG_DC_TICKS    = 3'd1,
		REG_LP_TICKS    = 3'd2,
		REG_DB_TICKS    = 3'd3,
		REG_CLICK_CODE  = 3'd4,
		REG_DOUBLE_CODE = 3'd5,
		REG_LONG_CODE   = 3'd6
	} cfg_reg_t;

endpackage

[src/button_gesture_classifier_core.sv]
// Top level of the button gesture classifier: input stage, classifier and result register.
//
// Usage: one sampled active-low button level enters per request on the input
// channel (in_valid, in_ready, pin_level). Every request yields exactly one
// result on the output channel (out_valid, out_ready, trigger, event_code):
// trigger 0 none, 1 click, 2 double click, 3 long press, with the configured
// event code for it. Registers are written through cfg_we, cfg_index and
// cfg_data; the user writes them only while no request is in flight (not enforced).
// The input register loads at the accepting edge; the classifier then updates
// its state and loads the result register once the result register is free.
// Throughput is one request per cycle while the receiver does not stall; the
// state update is a few compares and increments.
// When the receiver stalls, the result register holds its result and the input
// register still takes one more request; after that in_ready stays low until
// the result is taken.
// Reset clears both pipeline stages, sets the configuration to its defaults
// (button disabled, debounce hold-off of 100 ticks) and puts the button in the
// released, idle state with the hold-off expired.
module button_gesture_classifier_core #(
	parameter int TICK_WIDTH = bgc_pkg::TICK_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bgc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [bgc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           pin_level,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [bgc_pkg::TRIG_W-1:0]      trigger,
	output logic [bgc_pkg::CODE_W-1:0]      event_code
);
	import bgc_pkg::*;

	localparam int CW = (TICK_WIDTH > CFG_DATA_W) ? TICK_WIDTH : CFG_DATA_W;
	localparam logic [CW-1:0] TMAX_W = CW'({TICK_WIDTH{1'b1}});
	localparam logic [TICK_WIDTH-1:0] TMAX = {TICK_WIDTH{1'b1}};

	logic                  enabled_q;
	logic [CFG_DATA_W-1:0] dc_cfg_q;
	logic [CFG_DATA_W-1:0] lp_cfg_q;
	logic [CFG_DATA_W-1:0] db_cfg_q;
	logic [CODE_W-1:0]     click_code_q;
	logic [CODE_W-1:0]     double_code_q;
	logic [CODE_W-1:0]     long_code_q;

	logic                  settled_q;
	logic [1:0]            clicks_q;
	logic [TICK_WIDTH-1:0] gesture_q;
	logic [TICK_WIDTH-1:0] debounce_q;

	logic                  valid_s1;
	logic                  level_s1;
	logic                  out_valid_q;
	trig_t                 trigger_q;
	logic [CODE_W-1:0]     event_code_q;

	logic                  out_free;
	logic                  fire;

	logic [CW-1:0]         dc_w;
	logic [CW-1:0]         lp_w;
	logic [CW-1:0]         db_w;
	logic [TICK_WIDTH-1:0] dc_lim;
	logic [TICK_WIDTH-1:0] lp_raw;
	logic [TICK_WIDTH-1:0] lp_lim;
	logic [TICK_WIDTH-1:0] db_lim;

	logic                  settled_d;
	logic [1:0]            clicks_d;
	logic [TICK_WIDTH-1:0] gesture_d;
	logic [TICK_WIDTH-1:0] debounce_d;
	logic [TICK_WIDTH-1:0] gesture_inc;
	logic                  done;
	trig_t                 trig_d;
	logic [CODE_W-1:0]     code_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q     <= 1'b0;
			dc_cfg_q      <= '0;
			lp_cfg_q      <= '0;
			db_cfg_q      <= DEBOUNCE_RESET;
			click_code_q  <= '0;
			double_code_q <= '0;
			long_code_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLED:     enabled_q     <= cfg_data[0];
				REG_DC_TICKS:    dc_cfg_q      <= cfg_data;
				REG_LP_TICKS:    lp_cfg_q      <= cfg_data;
				REG_DB_TICKS:    db_cfg_q      <= cfg_data;
				REG_CLICK_CODE:  click_code_q  <= cfg_data[CODE_W-1:0];
				REG_DOUBLE_CODE: double_code_q <= cfg_data[CODE_W-1:0];
				REG_LONG_CODE:   long_code_q   <= cfg_data[CODE_W-1:0];
				default: ;
			endcase
		end
	end

	// Limits are saturated to the counter width so the counters never wrap.
	always_comb begin
		dc_w   = CW'(dc_cfg_q);
		lp_w   = CW'(lp_cfg_q);
		db_w   = CW'(db_cfg_q);
		dc_lim = (dc_w > TMAX_W) ? TMAX : TICK_WIDTH'(dc_w);
		lp_raw = (lp_w > TMAX_W) ? TMAX : TICK_WIDTH'(lp_w);
		db_lim = (db_w > TMAX_W) ? TMAX : TICK_WIDTH'(db_w);
		lp_lim = (lp_raw < dc_lim) ? dc_lim : lp_raw;
	end

	assign out_free = !out_valid_q || out_ready;
	assign fire     = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_comb begin
		settled_d   = settled_q;
		clicks_d    = clicks_q;
		gesture_d   = gesture_q;
		debounce_d  = debounce_q;
		gesture_inc = gesture_q + 1'b1;
		done        = 1'b0;
		trig_d      = TRIG_NONE;

		if (enabled_q) begin
			// The gesture timer is checked first; a timer event that emits a trigger ends the tick.
			if (gesture_q < lp_lim) begin
				gesture_d = gesture_inc;
				if (gesture_inc == dc_lim && settled_q && clicks_q == 2'd1) begin
					gesture_d = lp_lim;
					clicks_d  = 2'd0;
					trig_d    = TRIG_CLICK;
					done      = 1'b1;
				end else if (gesture_inc == lp_lim) begin
					gesture_d = lp_lim;
					clicks_d  = 2'd0;
					if (!settled_q && clicks_q == 2'd1) begin
						trig_d = TRIG_LONG;
						done   = 1'b1;
					end
				end
			end

			if (!done) begin
				if (debounce_q < db_lim) begin
					debounce_d = debounce_q + 1'b1;
				end else if (!level_s1) begin
					if (settled_q) begin
						settled_d  = 1'b0;
						debounce_d = '0;
						if (clicks_d == 2'd0) begin
							gesture_d = '0;
						end
						if (clicks_d < 2'd2) begin
							clicks_d = clicks_d + 2'd1;
						end
					end
				end else if (!settled_q) begin
					settled_d  = 1'b1;
					debounce_d = '0;
					if (clicks_d == 2'd1 && (double_code_q == '0 ||
					    (gesture_d >= dc_lim && gesture_d < lp_lim))) begin
						gesture_d = lp_lim;
						clicks_d  = 2'd0;
						trig_d    = TRIG_CLICK;
					end else if (clicks_d == 2'd2) begin
						gesture_d = lp_lim;
						clicks_d  = 2'd0;
						trig_d    = TRIG_DOUBLE;
					end
				end
			end
		end

		case (trig_d)
			TRIG_CLICK:  code_d = click_code_q;
			TRIG_DOUBLE: code_d = double_code_q;
			TRIG_LONG:   code_d = long_code_q;
			default:     code_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			level_s1 <= pin_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settled_q  <= 1'b1;
			clicks_q   <= 2'd0;
			gesture_q  <= TMAX;
			debounce_q <= TMAX;
		end else if (fire) begin
			settled_q  <= settled_d;
			clicks_q   <= clicks_d;
			gesture_q  <= gesture_d;
			debounce_q <= debounce_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			trigger_q    <= trig_d;
			event_code_q <= code_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign trigger    = trigger_q;
	assign event_code = event_code_q;

endmodule

[src/bgc_checker.sv]
// Port-level checker for the button gesture classifier and its bind statement.
`include "button_gesture_classifier_core_defines.svh"

module bgc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [bgc_pkg::TRIG_W-1:0]       trigger,
	input logic [bgc_pkg::CODE_W-1:0]       event_code
);
	import bgc_pkg::*;

	// A stalled result keeps its value until it is taken.
	`BGC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(trigger) && $stable(event_code), "stalled result changed")

	// With no trigger there is no event code.
	`BGC_ASSERT_NOW(a_none_code, out_valid && trigger == TRIG_NONE,
		event_code == '0, "event code set without a trigger")

	// The input side only stalls when a result is waiting on a stalled receiver.
	`BGC_ASSERT_NOW(a_backpressure, !in_ready,
		out_valid && !out_ready, "input stalled without output backpressure")

endmodule

bind button_gesture_classifier_core bgc_checker u_bgc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.trigger    (trigger),
	.event_code (event_code)
);
